>>> rtl/rhap_pkg.sv
// shared constants, codes and types for the rtp h.264 / aac packetizer
// no dependencies
package rhap_pkg;

   localparam int LENGTH_BITS = 20;
   localparam int FILL_W = 14;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int IDX_W = 5;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_TYPE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_ID = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMESTAMP_STEP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_SEQUENCE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TIMESTAMP = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 3'd5;

   localparam logic [FILL_W-1:0] MAX_PAYLOAD_RESET = 14'd1400;
   localparam logic [FILL_W-1:0] MAX_PAYLOAD_MIN = 14'd16;
   localparam logic [FILL_W-1:0] MAX_PAYLOAD_MAX = 14'd8192;
   localparam logic [6:0] PAYLOAD_TYPE_RESET = 7'd96;

   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
   localparam logic [7:0] AU_HDR_LEN_HI = 8'h00;
   localparam logic [7:0] AU_HDR_LEN_LO = 8'h10;
   localparam logic [7:0] FU_A_TYPE = 8'd28;
   localparam logic [7:0] FU_START_BIT = 8'h80;
   localparam logic [7:0] FU_END_BIT = 8'h40;
   localparam logic [7:0] NRI_MASK = 8'hE0;
   localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;

   localparam logic [IDX_W-1:0] RTP_HDR_BYTES = 5'd12;
   localparam logic [2:0] EXT_NONE = 3'd0;
   localparam logic [2:0] EXT_FU = 3'd2;
   localparam logic [2:0] EXT_AU = 3'd4;

   localparam logic CODEC_VIDEO = 1'b0;
   localparam logic CODEC_AUDIO = 1'b1;

   typedef struct packed {
      logic [6:0]        payload_type;
      logic [31:0]       source_id;
      logic [31:0]       ts_step;
      logic [FILL_W-1:0] max_payload;   // already clamped to 16..8192
   } cfg_type;

   typedef struct packed {
      logic        seq_load;
      logic [15:0] seq_value;
      logic        ts_load;
      logic [31:0] ts_value;
   } load_type;

   // everything needed to send the bytes caused by one input item
   typedef struct packed {
      logic        has_hdr;
      logic [2:0]  ext_bytes;
      logic        marker;
      logic [6:0]  payload_type;
      logic [15:0] seq;
      logic [31:0] ts;
      logic [31:0] ssrc;
      logic [31:0] ext;        // first extra byte in the top bits
      logic [7:0]  data;
      logic        pkt_end;
   } pkt_type;

endpackage

>>> rtl/rtp_h264_aac_packetizer_unit.sv
// rtp packetizer for h.264 nal units (single or fu-a) and aac frames
// an input item goes through the core input register, then the emit result register
// throughput: 1 input item per cycle for media bytes inside a packet while rsp_tready
// is high; an item that opens a packet holds the output register for its header bytes
// reset: synchronous; counters, framing state, valid flags and csrs return to defaults
// depends on rhap_pkg, rhap_csr, rhap_core, rhap_emit
module rtp_h264_aac_packetizer_unit
   import rhap_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // data_byte[7:0], frame_length[27:8], zero pad
   input  logic [1:0]            req_tuser,   // codec[0], frame_start[1]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // out_byte[7:0]
   output logic                  rsp_tlast,   // packet_end
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg;
   load_type load;
   pkt_type  pkt;
   logic     pkt_valid;
   logic     take;

   rhap_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .load      (load)
   );

   rhap_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg),
      .load       (load),
      .take       (take),
      .pkt_valid  (pkt_valid),
      .pkt        (pkt)
   );

   rhap_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .pkt_valid  (pkt_valid),
      .pkt        (pkt),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // an empty output register never holds back the input side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output register");

   // the bytes of one item leave without gaps
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast && !take) |=> rsp_tvalid)
      else $error("gap inside an item's header bytes");

   // a new packet item is only loaded when the output register can take it
   assert property (@(posedge clock) disable iff (reset)
      pkt_valid |-> take)
      else $error("output register overwritten");

endmodule

>>> rtl/rhap_csr.sv
// configuration registers of the packetizer, with payload limit clamping
// depends on rhap_pkg
module rhap_csr
   import rhap_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg,
   output load_type              load
);

   logic [6:0]        pt_ff;
   logic [31:0]       ssrc_ff;
   logic [31:0]       step_ff;
   logic [FILL_W-1:0] mp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff   <= PAYLOAD_TYPE_RESET;
         ssrc_ff <= '0;
         step_ff <= '0;
         mp_ff   <= MAX_PAYLOAD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PAYLOAD_TYPE:   pt_ff <= csr_wdata[6:0];
            CSR_SOURCE_ID:      ssrc_ff <= csr_wdata;
            CSR_TIMESTAMP_STEP: step_ff <= csr_wdata;
            CSR_MAX_PAYLOAD:    mp_ff <= csr_wdata[FILL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.payload_type = pt_ff;
      cfg.source_id    = ssrc_ff;
      cfg.ts_step      = step_ff;
      if (mp_ff < MAX_PAYLOAD_MIN) begin
         cfg.max_payload = MAX_PAYLOAD_MIN;
      end else if (mp_ff > MAX_PAYLOAD_MAX) begin
         cfg.max_payload = MAX_PAYLOAD_MAX;
      end else begin
         cfg.max_payload = mp_ff;
      end
   end

   // start values only seed the running counters
   assign load.seq_load  = csr_we && (csr_index == CSR_START_SEQUENCE);
   assign load.seq_value = csr_wdata[15:0];
   assign load.ts_load   = csr_we && (csr_index == CSR_START_TIMESTAMP);
   assign load.ts_value  = csr_wdata;

endmodule

>>> rtl/rhap_core.sv
// input register, framing state and per-byte packet decision
// depends on rhap_pkg
module rhap_core
   import rhap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  cfg_type     cfg,
   input  load_type    load,
   input  logic        take,
   output logic        pkt_valid,
   output pkt_type     pkt
);

   logic                   in_valid_ff;
   logic [7:0]             byte_ff;
   logic                   codec_ff;
   logic [LENGTH_BITS-1:0] len_ff;
   logic                   start_ff;

   logic [15:0]            seq_ff, seq_in;
   logic [31:0]            ts_ff, ts_in;
   logic [7:0]             nh_ff, nh_in;
   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic                   single_ff, single_in;

   logic                   advance;
   logic                   has_result;
   logic                   pkt_end;

   always_comb begin
      logic [LENGTH_BITS-1:0] p;
      logic [LENGTH_BITS-1:0] rem;
      logic [LENGTH_BITS-1:0] mx_ext;
      logic [FILL_W-1:0]      fill_e;
      logic [FILL_W:0]        fill_inc;
      logic                   in_range;
      logic                   first;
      logic                   single_e;
      logic                   fu;
      logic                   skip_fu;
      logic                   last;
      logic                   q_zero;
      logic [7:0]             nh_e;
      logic [7:0]             fu_hdr;
      logic [12:0]            sz;

      mx_ext   = {{(LENGTH_BITS-FILL_W){1'b0}}, cfg.max_payload};
      p        = start_ff ? '0 : pos_ff;
      fill_e   = start_ff ? '0 : fill_ff;
      in_range = p < len_ff;
      first    = (p == '0);
      nh_e     = first ? byte_ff : nh_ff;
      single_e = first ? ((codec_ff == CODEC_VIDEO) && (len_ff < mx_ext)) : single_ff;
      if (first) begin
         fill_e = '0;
      end
      fu       = (codec_ff == CODEC_VIDEO) && !single_e;
      // the nalu header byte of a fragmented unit is only latched
      skip_fu  = fu && first;
      rem      = len_ff - p;
      last     = rem <= mx_ext;
      q_zero   = (p == {{(LENGTH_BITS-1){1'b0}}, 1'b1});
      fill_inc = {1'b0, fill_e} + {{FILL_W{1'b0}}, 1'b1};
      pkt_end  = (fill_inc >= {1'b0, cfg.max_payload}) ||
                 (rem == {{(LENGTH_BITS-1){1'b0}}, 1'b1});
      has_result = in_range && !skip_fu;

      fu_hdr = nh_e & NAL_TYPE_MASK;
      if (q_zero) begin
         fu_hdr = fu_hdr | FU_START_BIT;
      end
      if (last) begin
         fu_hdr = fu_hdr | FU_END_BIT;
      end
      sz = len_ff[12:0];

      pkt.has_hdr      = (fill_e == '0);
      pkt.marker       = last;
      pkt.payload_type = cfg.payload_type;
      pkt.seq          = seq_ff;
      pkt.ts           = ts_ff;
      pkt.ssrc         = cfg.source_id;
      pkt.data         = byte_ff;
      pkt.pkt_end      = pkt_end;
      if (codec_ff == CODEC_AUDIO) begin
         pkt.ext_bytes = EXT_AU;
         pkt.ext       = {AU_HDR_LEN_HI, AU_HDR_LEN_LO, sz[12:5], sz[4:0], 3'b000};
      end else if (fu) begin
         pkt.ext_bytes = EXT_FU;
         pkt.ext       = {(nh_e & NRI_MASK) | FU_A_TYPE, fu_hdr, 16'h0000};
      end else begin
         pkt.ext_bytes = EXT_NONE;
         pkt.ext       = '0;
      end

      // framing state after this byte
      nh_in     = in_range ? nh_e : nh_ff;
      single_in = in_range ? single_e : single_ff;
      if (!in_range) begin
         pos_in  = p;
         fill_in = fill_e;
      end else if (skip_fu) begin
         pos_in  = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
         fill_in = '0;
      end else begin
         pos_in  = p + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
         fill_in = pkt_end ? '0 : fill_inc[FILL_W-1:0];
      end
      if (has_result && pkt_end) begin
         seq_in = seq_ff + 16'd1;
         ts_in  = ts_ff + cfg.ts_step;
      end else begin
         seq_in = seq_ff;
         ts_in  = ts_ff;
      end
   end

   assign advance    = in_valid_ff && (!has_result || take);
   assign req_tready = !in_valid_ff || advance;
   assign pkt_valid  = advance && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         byte_ff  <= req_tdata[7:0];
         len_ff   <= req_tdata[8 +: LENGTH_BITS];
         codec_ff <= req_tuser[0];
         start_ff <= req_tuser[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= '0;
         ts_ff     <= '0;
         nh_ff     <= '0;
         pos_ff    <= '0;
         fill_ff   <= '0;
         single_ff <= 1'b0;
      end else begin
         if (advance) begin
            nh_ff     <= nh_in;
            pos_ff    <= pos_in;
            fill_ff   <= fill_in;
            single_ff <= single_in;
         end
         if (load.seq_load) begin
            seq_ff <= load.seq_value;
         end else if (advance) begin
            seq_ff <= seq_in;
         end
         if (load.ts_load) begin
            ts_ff <= load.ts_value;
         end else if (advance) begin
            ts_ff <= ts_in;
         end
      end
   end

endmodule

>>> rtl/rhap_emit.sv
// result register: sends the header bytes, if any, and the media byte of one item
// depends on rhap_pkg
module rhap_emit
   import rhap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       pkt_valid,
   input  pkt_type    pkt,
   output logic       take,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast
);

   logic             valid_ff;
   pkt_type          pkt_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] last_idx;
   logic             at_last;
   logic             fire;

   assign last_idx = pkt_ff.has_hdr ? (RTP_HDR_BYTES + {2'b00, pkt_ff.ext_bytes}) : '0;
   assign at_last  = (idx_ff == last_idx);
   assign fire     = valid_ff && rsp_tready;
   assign take     = !valid_ff || (rsp_tready && at_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (pkt_valid) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (fire && at_last) begin
         valid_ff <= 1'b0;
      end else if (fire) begin
         idx_ff <= idx_ff + {{(IDX_W-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (pkt_valid) begin
         pkt_ff <= pkt;
      end
   end

   always_comb begin
      if (at_last) begin
         rsp_tdata = pkt_ff.data;
      end else begin
         case (idx_ff)
            5'd0:    rsp_tdata = RTP_VERSION_BYTE;
            5'd1:    rsp_tdata = {pkt_ff.marker, pkt_ff.payload_type};
            5'd2:    rsp_tdata = pkt_ff.seq[15:8];
            5'd3:    rsp_tdata = pkt_ff.seq[7:0];
            5'd4:    rsp_tdata = pkt_ff.ts[31:24];
            5'd5:    rsp_tdata = pkt_ff.ts[23:16];
            5'd6:    rsp_tdata = pkt_ff.ts[15:8];
            5'd7:    rsp_tdata = pkt_ff.ts[7:0];
            5'd8:    rsp_tdata = pkt_ff.ssrc[31:24];
            5'd9:    rsp_tdata = pkt_ff.ssrc[23:16];
            5'd10:   rsp_tdata = pkt_ff.ssrc[15:8];
            5'd11:   rsp_tdata = pkt_ff.ssrc[7:0];
            5'd12:   rsp_tdata = pkt_ff.ext[31:24];
            5'd13:   rsp_tdata = pkt_ff.ext[23:16];
            5'd14:   rsp_tdata = pkt_ff.ext[15:8];
            5'd15:   rsp_tdata = pkt_ff.ext[7:0];
            default: rsp_tdata = pkt_ff.data;
         endcase
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = at_last && pkt_ff.pkt_end;

endmodule

>>> bench/rtp_h264_aac_packetizer_unit_tb.sv
// self-checking bench for rtp_h264_aac_packetizer_unit: frame bytes in, rtp packet bytes out
// a packet model predicts every output byte; needs rhap_pkg and the packetizer rtl
module rtp_h264_aac_packetizer_unit_tb;
   import rhap_pkg::*;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } rtp_byte_type;

   class rtp_packet_model;
      logic [6:0]   payload_type;
      logic [31:0]  ssrc;
      logic [31:0]  ts_step;
      logic [13:0]  max_payload;
      logic [15:0]  seq_num;
      logic [31:0]  ts_now;
      logic [7:0]   nalu_hdr;
      int           pos;
      int           fill;
      bit           single_nalu;
      rtp_byte_type bytes_due[$];
      int           mismatches;

      function new();
         payload_type = PAYLOAD_TYPE_RESET;
         ssrc = '0;
         ts_step = '0;
         max_payload = MAX_PAYLOAD_RESET;
         seq_num = '0;
         ts_now = '0;
         nalu_hdr = '0;
         pos = 0;
         fill = 0;
         single_nalu = 1'b0;
         mismatches = 0;
      endfunction

      function int payload_limit();
         if (max_payload < MAX_PAYLOAD_MIN) return int'(MAX_PAYLOAD_MIN);
         if (max_payload > MAX_PAYLOAD_MAX) return int'(MAX_PAYLOAD_MAX);
         return int'(max_payload);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
         case (idx)
            CSR_PAYLOAD_TYPE: payload_type = v[6:0];
            CSR_SOURCE_ID: ssrc = v;
            CSR_TIMESTAMP_STEP: ts_step = v;
            CSR_START_SEQUENCE: seq_num = v[15:0];
            CSR_START_TIMESTAMP: ts_now = v;
            CSR_MAX_PAYLOAD: max_payload = v[13:0];
            default: ;
         endcase
      endfunction

      function void due(logic [7:0] v, logic l);
         bytes_due.push_back({v, l});
      endfunction

      // returns the number of packet bytes this frame byte causes
      function int take_frame_byte(logic [7:0] b, logic codec, logic [19:0] len, logic start);
         int         mx;
         int         flen;
         int         p;
         int         q;
         int         total;
         int         n0;
         bit         fu;
         bit         last_pkt;
         bit         is_end;
         logic [7:0] fu_hdr;
         logic [12:0] sz;
         mx = payload_limit();
         flen = int'(len);
         n0 = bytes_due.size();
         if (start) begin
            pos = 0;
            fill = 0;
         end
         p = pos;
         if (p >= flen) return 0;
         if (p == 0) begin
            nalu_hdr = b;
            single_nalu = (codec == CODEC_VIDEO) && (flen < mx);
            fill = 0;
         end
         fu = (codec == CODEC_VIDEO) && !single_nalu;
         // fu-a: the nal header byte is only latched
         if (fu && p == 0) begin
            pos = 1;
            return 0;
         end
         q = p - int'(fu);
         total = flen - int'(fu);
         if (fill == 0) begin
            last_pkt = (total - q) <= mx;
            due(RTP_VERSION_BYTE, 1'b0);
            due({last_pkt, payload_type}, 1'b0);
            due(seq_num[15:8], 1'b0);
            due(seq_num[7:0], 1'b0);
            due(ts_now[31:24], 1'b0);
            due(ts_now[23:16], 1'b0);
            due(ts_now[15:8], 1'b0);
            due(ts_now[7:0], 1'b0);
            due(ssrc[31:24], 1'b0);
            due(ssrc[23:16], 1'b0);
            due(ssrc[15:8], 1'b0);
            due(ssrc[7:0], 1'b0);
            if (codec == CODEC_AUDIO) begin
               sz = len[12:0];
               due(AU_HDR_LEN_HI, 1'b0);
               due(AU_HDR_LEN_LO, 1'b0);
               due(sz[12:5], 1'b0);
               due({sz[4:0], 3'b000}, 1'b0);
            end else if (fu) begin
               fu_hdr = nalu_hdr & NAL_TYPE_MASK;
               if (q == 0) fu_hdr = fu_hdr | FU_START_BIT;
               if (last_pkt) fu_hdr = fu_hdr | FU_END_BIT;
               due((nalu_hdr & NRI_MASK) | FU_A_TYPE, 1'b0);
               due(fu_hdr, 1'b0);
            end
         end
         is_end = (fill + 1 >= mx) || (q + 1 == total);
         due(b, is_end);
         if (is_end) begin
            seq_num = seq_num + 16'd1;
            ts_now = ts_now + ts_step;
            fill = 0;
         end else begin
            fill = fill + 1;
         end
         pos = p + 1;
         return bytes_due.size() - n0;
      endfunction

      function void check_packet_byte(logic [7:0] v, logic l);
         rtp_byte_type e;
         if (bytes_due.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual byte %02h last %0b",
                     $time, v, l);
            mismatches++;
            return;
         end
         e = bytes_due.pop_front();
         if (v !== e.value) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, e.value, v);
            mismatches++;
         end
         if (l !== e.last) begin
            $display("%0t: packet_end expected %0b actual %0b", $time, e.last, l);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;   // data_byte[7:0], frame_length[27:8], zero pad
   logic [1:0]            req_tuser;   // codec[0], frame_start[1]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;   // out_byte[7:0]
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rtp_packet_model pkt_model;
   bit  send_calm;
   bit  rsp_calm;
   bit  long_hold;
   int  busy_items;

   rtp_h264_aac_packetizer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) pkt_model.check_packet_byte(rsp_tdata, rsp_tlast);
   end

   // receiver: random stalls per item, plus one long hold-off on request
   initial begin
      int gap;
      rsp_tready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         gap = rsp_calm ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   task automatic send_byte(logic [7:0] b, logic codec, logic [19:0] len, logic start);
      int gap;
      int n;
      gap = send_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, len, b};
      req_tuser <= {start, codec};
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
      n = pkt_model.take_frame_byte(b, codec, len, start);
      if (n > 0) busy_items++;
   endtask

   // wait until every predicted byte is out and the pipe has emptied
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pkt_model.bytes_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      pkt_model.write_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic run_frame();
      int          kind;
      int          mx;
      int          flen;
      int          count;
      logic        codec;
      logic        bcodec;
      logic [19:0] len;
      logic [19:0] blen;
      mx = pkt_model.payload_limit();
      kind = $urandom_range(0, 9);
      codec = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: flen = mx - 1 + $urandom_range(0, 3);
         1: flen = 2 * mx + $urandom_range(0, 1);
         default: flen = $urandom_range(1, 40);
      endcase
      if (flen > 100) flen = $urandom_range(1, 40);
      len = 20'(flen);
      count = flen;
      // truncated frame with a length anywhere in the field's range
      if (kind == 7) begin
         len = 20'($urandom_range(1, 20'hFFFFF));
         count = $urandom_range(1, 6);
      end
      for (int i = 0; i < count; i++) begin
         bcodec = codec;
         blen = len;
         if (kind == 9 && $urandom_range(0, 3) == 0) bcodec = ~codec;
         if (kind == 9 && $urandom_range(0, 3) == 0) blen = 20'($urandom_range(1, 60));
         send_byte(8'($urandom_range(0, 255)), bcodec, blen, (i == 0) && (kind != 8));
      end
      // stray bytes beyond the frame's end
      if (kind == 8) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), codec, len, 1'b0);
      end
   endtask

   initial begin
      logic [31:0] mp;
      pkt_model = new();
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      send_calm = 1'b0;
      rsp_calm = 1'b0;
      long_hold = 1'b0;
      busy_items = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: first byte with no frame start, single nalu, aac, ignored bytes
      send_byte(8'h00, CODEC_VIDEO, 20'd1, 1'b0);
      send_byte(8'hFF, CODEC_AUDIO, 20'd2, 1'b1);
      send_byte(8'hFF, CODEC_AUDIO, 20'd2, 1'b0);
      send_byte(8'h5A, CODEC_AUDIO, 20'd2, 1'b0);
      send_byte(8'h33, CODEC_VIDEO, 20'd0, 1'b1);
      // aac size field takes only the low 13 bits of the length
      send_byte(8'hA5, CODEC_AUDIO, 20'hFFFFF, 1'b1);
      send_byte(8'h5A, CODEC_AUDIO, 20'hFFFFF, 1'b0);
      settle();

      // payload limit below range, all other registers at their top values
      write_csr(CSR_MAX_PAYLOAD, 32'd5);
      write_csr(CSR_PAYLOAD_TYPE, 32'd127);
      write_csr(CSR_SOURCE_ID, 32'hFFFF_FFFF);
      write_csr(CSR_TIMESTAMP_STEP, 32'hFFFF_FFFF);
      write_csr(CSR_START_SEQUENCE, 32'h0000_FFFF);
      write_csr(CSR_START_TIMESTAMP, 32'hFFFF_FFFF);
      // nalu as long as the limit: one fu-a fragment with start and end bits
      send_byte(8'hFC, CODEC_VIDEO, 20'd16, 1'b1);
      for (int i = 1; i < 16; i++) begin
         send_byte(8'($urandom_range(0, 255)), CODEC_VIDEO, 20'd16, 1'b0);
      end
      settle();

      busy_items = 0;
      for (int phase = 0; busy_items < 400; phase++) begin
         case (phase % 8)
            0: mp = 32'd16;
            1: mp = 32'd0;
            2: mp = 32'd20;
            3: mp = 32'd8192;
            4: mp = 32'd15;
            5: mp = 32'd16383;
            6: mp = $urandom_range(17, 48);
            default: mp = 32'd1400;
         endcase
         write_csr(CSR_MAX_PAYLOAD, mp);
         write_csr(CSR_PAYLOAD_TYPE, (phase == 1) ? 32'd0 : $urandom_range(0, 127));
         write_csr(CSR_SOURCE_ID, (phase % 3 == 0) ? 32'd0 : $urandom());
         write_csr(CSR_TIMESTAMP_STEP, (phase % 4 == 1) ? 32'd0 : $urandom());
         write_csr(CSR_START_SEQUENCE, (phase % 2 == 1) ? 32'h0000_FFFF : $urandom_range(0, 65535));
         write_csr(CSR_START_TIMESTAMP, (phase == 1) ? 32'd0 : $urandom());
         send_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         if (phase == 2) send_calm = 1'b1;
         for (int f = 0; f < 4 && busy_items < 400; f++) begin
            run_frame();
            // output side stops while input keeps coming until the block backs up
            if (phase == 2 && f == 0) long_hold = 1'b1;
         end
         settle();
      end

      if (pkt_model.mismatches == 0 && pkt_model.bytes_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

>>> files.f
rtl/rhap_pkg.sv
rtl/rhap_csr.sv
rtl/rhap_core.sv
rtl/rhap_emit.sv
rtl/rtp_h264_aac_packetizer_unit.sv
bench/rtp_h264_aac_packetizer_unit_tb.sv
